/* hw/rtl/pbfs_pkg.sv */
// ----------------------------------------------------------------------------
// pbfs_pkg - shared definitions for the projected bounding box fit scale core
// Widths, register indexes, reset values, controller state codes and the
// command and status words between controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pbfs_pkg;

   // Default parameter values
   localparam int COORD_BITS_DEF     = 12;
   localparam int COEF_FRAC_BITS_DEF = 14;

   // Fixed field widths
   localparam int COEF_W     = 24;
   localparam int HGT_W      = 16;
   localparam int VIEW_W     = 14;
   localparam int STATE_W    = 48;
   localparam int SCALE_W    = 32;
   localparam int SCALE_FRAC = 16;
   localparam int CSR_ADDR_W = 3;

   // Register indexes
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_XX  = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_XY  = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_XZ  = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_YX  = 3'd3;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_YY  = 3'd4;
   localparam logic [CSR_ADDR_W-1:0] REG_COEF_YZ  = 3'd5;
   localparam logic [CSR_ADDR_W-1:0] REG_VIEW_W   = 3'd6;
   localparam logic [CSR_ADDR_W-1:0] REG_VIEW_H   = 3'd7;

   // Register reset values
   localparam logic signed [COEF_W-1:0] RST_COEF_UNIT = 24'sd16384;
   localparam logic signed [COEF_W-1:0] RST_COEF_ZERO = 24'sd0;
   localparam logic [VIEW_W-1:0]        RST_VIEW_W    = 14'd1920;
   localparam logic [VIEW_W-1:0]        RST_VIEW_H    = 14'd1080;

   // Controller states
   typedef enum logic [8:0] {
      S_IDLE = 9'b000000001,
      S_PROJ = 9'b000000010,
      S_SUM  = 9'b000000100,
      S_BOX  = 9'b000001000,
      S_EXT  = 9'b000010000,
      S_LOAD = 9'b000100000,
      S_DIV  = 9'b001000000,
      S_PICK = 9'b010000000,
      S_DONE = 9'b100000000
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic capture;   // latch the accepted point
      logic mult;      // form the six coefficient products
      logic sum;       // add products into projected x and y
      logic box;       // fold projected point into the bounding box
      logic ext;       // form both extents
      logic div_load;  // load divider for the selected axis
      logic div_step;  // one quotient bit
      logic pick;      // keep the smaller axis scale
      logic finish;    // load result word, clear the box
      logic axis;      // 0 = x axis, 1 = y axis
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic last_pt;   // captured point closes the map
      logic ex_zero;   // x extent is zero
      logic ey_zero;   // y extent is zero
      logic div_last;  // divider on its final step
      logic rsp_full;  // result word still waiting
   } sts_type;

endpackage

/* hw/rtl/pbfs_ctrl.sv */
// ----------------------------------------------------------------------------
// pbfs_ctrl - sequencer of the fit scale core
// Walks each point through multiply, sum and box update, and on the last
// point runs the shared divider over each nonzero axis and commits the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbfs_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  pbfs_pkg::sts_type sts,
   output pbfs_pkg::cmd_type cmd
);

   pbfs_pkg::state_type state_ff, state_in;
   logic                axis_ff, axis_in;

   // Next state and command decode
   always_comb begin
      state_in  = state_ff;
      axis_in   = axis_ff;
      req_ready = 1'b0;
      cmd       = '0;
      cmd.axis  = axis_ff;
      unique case (state_ff)
         pbfs_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = pbfs_pkg::S_PROJ;
            end
         end
         pbfs_pkg::S_PROJ: begin
            cmd.mult = 1'b1;
            state_in = pbfs_pkg::S_SUM;
         end
         pbfs_pkg::S_SUM: begin
            cmd.sum  = 1'b1;
            state_in = pbfs_pkg::S_BOX;
         end
         pbfs_pkg::S_BOX: begin
            cmd.box  = 1'b1;
            state_in = sts.last_pt ? pbfs_pkg::S_EXT : pbfs_pkg::S_IDLE;
         end
         pbfs_pkg::S_EXT: begin
            // start on x unless its extent is zero
            cmd.ext  = 1'b1;
            axis_in  = sts.ex_zero;
            state_in = (sts.ex_zero && sts.ey_zero) ? pbfs_pkg::S_DONE : pbfs_pkg::S_LOAD;
         end
         pbfs_pkg::S_LOAD: begin
            cmd.div_load = 1'b1;
            state_in     = pbfs_pkg::S_DIV;
         end
         pbfs_pkg::S_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = pbfs_pkg::S_PICK;
            end
         end
         pbfs_pkg::S_PICK: begin
            cmd.pick = 1'b1;
            if (!axis_ff && !sts.ey_zero) begin
               axis_in  = 1'b1;
               state_in = pbfs_pkg::S_LOAD;
            end else begin
               state_in = pbfs_pkg::S_DONE;
            end
         end
         pbfs_pkg::S_DONE: begin
            // wait for the result register to drain
            if (!sts.rsp_full) begin
               cmd.finish = 1'b1;
               state_in   = pbfs_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = pbfs_pkg::S_IDLE;
         end
      endcase
   end

   // State registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= pbfs_pkg::S_IDLE;
         axis_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         axis_ff  <= axis_in;
      end
   end

endmodule

/* hw/rtl/pbfs_dp.sv */
// ----------------------------------------------------------------------------
// pbfs_dp - datapath of the fit scale core
// Holds the projection registers, the running bounding box, a one bit per
// cycle restoring divider shared by both axes, and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pbfs_dp #(
   parameter int COORD_BITS     = pbfs_pkg::COORD_BITS_DEF,
   parameter int COEF_FRAC_BITS = pbfs_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   // point word: grid_col, grid_row, height_val from bit 0 up
   input  logic [((2*COORD_BITS+pbfs_pkg::HGT_W+7)/8)*8-1:0] req_tdata,
   input  logic                                req_tlast,
   input  logic                                csr_valid,
   input  logic [pbfs_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [pbfs_pkg::COEF_W-1:0]         csr_wdata,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [pbfs_pkg::SCALE_W-1:0]        rsp_tdata,
   output logic                                rsp_tuser,
   input  pbfs_pkg::cmd_type                   cmd,
   output pbfs_pkg::sts_type                   sts
);

   localparam int COEF_W  = pbfs_pkg::COEF_W;
   localparam int HGT_W   = pbfs_pkg::HGT_W;
   localparam int VIEW_W  = pbfs_pkg::VIEW_W;
   localparam int STATE_W = pbfs_pkg::STATE_W;
   localparam int SCALE_W = pbfs_pkg::SCALE_W;
   localparam int PC_W    = COORD_BITS + 1 + COEF_W;
   localparam int PH_W    = HGT_W + COEF_W;
   localparam int SHIFT   = pbfs_pkg::SCALE_FRAC + COEF_FRAC_BITS;
   localparam int NUM_W   = VIEW_W + 4 + SHIFT;
   localparam int DEN_W   = STATE_W + 4;
   localparam int CNT_W   = $clog2(NUM_W);

   localparam logic signed [STATE_W-1:0] BOX_MAX = {1'b0, {(STATE_W-1){1'b1}}};
   localparam logic signed [STATE_W-1:0] BOX_MIN = {1'b1, {(STATE_W-1){1'b0}}};

   // Configuration registers
   logic signed [COEF_W-1:0] cxx_ff, cxy_ff, cxz_ff, cyx_ff, cyy_ff, cyz_ff;
   logic [VIEW_W-1:0]        vw_ff, vh_ff;

   // Point and projection
   logic [COORD_BITS-1:0]   col_ff, row_ff;
   logic signed [HGT_W-1:0] hgt_ff;
   logic                    last_ff;
   logic signed [PC_W-1:0]  pxc_ff, pxr_ff, pyc_ff, pyr_ff;
   logic signed [PH_W-1:0]  pxh_ff, pyh_ff;
   logic signed [STATE_W-1:0] px_ff, py_ff;

   // Bounding box
   logic signed [STATE_W-1:0] minx_ff, maxx_ff, miny_ff, maxy_ff;
   logic [STATE_W-1:0]        ex_ff, ey_ff;

   // Divider
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [DEN_W-1:0]  den_ff, den_in, rem_ff, rem_in;
   logic [CNT_W-1:0]  cnt_ff;
   logic [DEN_W:0]    shifted, trial;
   logic              qbit;
   logic [VIEW_W-1:0] view_sel;
   logic [VIEW_W+3:0] nine_view;
   logic [STATE_W-1:0] ext_sel;

   // Best scale and result
   logic [NUM_W-1:0]   best_ff;
   logic               have_ff;
   logic               deg;
   logic               rsp_valid_ff;
   logic [SCALE_W-1:0] rsp_data_ff;
   logic               rsp_deg_ff;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cxx_ff <= pbfs_pkg::RST_COEF_UNIT;
         cxy_ff <= pbfs_pkg::RST_COEF_ZERO;
         cxz_ff <= pbfs_pkg::RST_COEF_ZERO;
         cyx_ff <= pbfs_pkg::RST_COEF_ZERO;
         cyy_ff <= pbfs_pkg::RST_COEF_UNIT;
         cyz_ff <= pbfs_pkg::RST_COEF_ZERO;
         vw_ff  <= pbfs_pkg::RST_VIEW_W;
         vh_ff  <= pbfs_pkg::RST_VIEW_H;
      end else if (csr_valid) begin
         unique case (csr_addr)
            pbfs_pkg::REG_COEF_XX: cxx_ff <= csr_wdata;
            pbfs_pkg::REG_COEF_XY: cxy_ff <= csr_wdata;
            pbfs_pkg::REG_COEF_XZ: cxz_ff <= csr_wdata;
            pbfs_pkg::REG_COEF_YX: cyx_ff <= csr_wdata;
            pbfs_pkg::REG_COEF_YY: cyy_ff <= csr_wdata;
            pbfs_pkg::REG_COEF_YZ: cyz_ff <= csr_wdata;
            pbfs_pkg::REG_VIEW_W:  vw_ff  <= csr_wdata[VIEW_W-1:0];
            pbfs_pkg::REG_VIEW_H:  vh_ff  <= csr_wdata[VIEW_W-1:0];
            default: ;
         endcase
      end
   end

   // Capture point, multiply, sum
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         col_ff  <= req_tdata[COORD_BITS-1:0];
         row_ff  <= req_tdata[2*COORD_BITS-1:COORD_BITS];
         hgt_ff  <= req_tdata[2*COORD_BITS+HGT_W-1:2*COORD_BITS];
         last_ff <= req_tlast;
      end
      if (cmd.mult) begin
         pxc_ff <= $signed({1'b0, col_ff}) * cxx_ff;
         pxr_ff <= $signed({1'b0, row_ff}) * cxy_ff;
         pxh_ff <= hgt_ff * cxz_ff;
         pyc_ff <= $signed({1'b0, col_ff}) * cyx_ff;
         pyr_ff <= $signed({1'b0, row_ff}) * cyy_ff;
         pyh_ff <= hgt_ff * cyz_ff;
      end
      if (cmd.sum) begin
         px_ff <= STATE_W'(pxc_ff) + STATE_W'(pxr_ff) + STATE_W'(pxh_ff);
         py_ff <= STATE_W'(pyc_ff) + STATE_W'(pyr_ff) + STATE_W'(pyh_ff);
      end
      if (cmd.ext) begin
         ex_ff <= STATE_W'(maxx_ff - minx_ff);
         ey_ff <= STATE_W'(maxy_ff - miny_ff);
      end
   end

   // Fold point into the box, clear after a result
   always_ff @(posedge clock) begin
      if (reset || cmd.finish) begin
         minx_ff <= BOX_MAX;
         miny_ff <= BOX_MAX;
         maxx_ff <= BOX_MIN;
         maxy_ff <= BOX_MIN;
      end else if (cmd.box) begin
         if (px_ff < minx_ff) minx_ff <= px_ff;
         if (px_ff > maxx_ff) maxx_ff <= px_ff;
         if (py_ff < miny_ff) miny_ff <= py_ff;
         if (py_ff > maxy_ff) maxy_ff <= py_ff;
      end
   end

   // Divider load values: 9*view shifted up, 10*extent
   always_comb begin
      view_sel  = cmd.axis ? vh_ff : vw_ff;
      ext_sel   = cmd.axis ? ey_ff : ex_ff;
      nine_view = {1'b0, view_sel, 3'b000} + {4'b0000, view_sel};
      shifted   = {rem_ff, num_ff[NUM_W-1]};
      trial     = shifted - {1'b0, den_ff};
      qbit      = !trial[DEN_W];
      num_in    = num_ff;
      den_in    = den_ff;
      rem_in    = rem_ff;
      if (cmd.div_load) begin
         num_in = {nine_view, {SHIFT{1'b0}}};
         den_in = {1'b0, ext_sel, 3'b000} + {3'b000, ext_sel, 1'b0};
         rem_in = '0;
      end else if (cmd.div_step) begin
         // restoring step; quotient bits shift in behind the dividend
         num_in = {num_ff[NUM_W-2:0], qbit};
         rem_in = qbit ? trial[DEN_W-1:0] : shifted[DEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      rem_ff <= rem_in;
      if (cmd.div_load) begin
         cnt_ff <= '0;
      end else if (cmd.div_step) begin
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
   end

   // Keep the smaller axis scale
   always_ff @(posedge clock) begin
      if (reset || cmd.ext) begin
         have_ff <= 1'b0;
      end else if (cmd.pick) begin
         have_ff <= 1'b1;
      end
      if (cmd.pick && (!have_ff || num_ff < best_ff)) begin
         best_ff <= num_ff;
      end
   end

   // Saturate when no axis counted or the scale does not fit
   assign deg = !have_ff || (|best_ff[NUM_W-1:SCALE_W]);

   // Result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
      if (cmd.finish) begin
         rsp_data_ff <= deg ? {SCALE_W{1'b1}} : best_ff[SCALE_W-1:0];
         rsp_deg_ff  <= deg;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_deg_ff;

   // Status
   always_comb begin
      sts.last_pt  = last_ff;
      sts.ex_zero  = (maxx_ff == minx_ff);
      sts.ey_zero  = (maxy_ff == miny_ff);
      sts.div_last = (cnt_ff == CNT_W'(NUM_W - 1));
      sts.rsp_full = rsp_valid_ff;
   end

endmodule

/* hw/rtl/projected_bbox_fit_scale_core.sv */
// ----------------------------------------------------------------------------
// projected_bbox_fit_scale_core - fit a projected point cloud into the view
// Each point (column, row, height) is projected linearly to screen x and y
// with six programmable Q9.14 weights and folded into a running bounding box.
// A point passes accept, multiply, sum and box update before the next one is
// accepted. A point marked tlast adds the scale computation: the extents,
// then for each axis with a nonzero extent a load, the steps of the shared
// restoring divider, which yields one quotient bit per cycle, and a pick;
// last the result is committed. The result is min(0.9*view_width/extent_x,
// 0.9*view_height/extent_y) in unsigned Q16.16, a zero extent dropping out;
// if both extents are zero or the scale exceeds 32 bits the scale reads all
// ones and tuser is set. The box clears after each result. The result sits
// in an output register, so the next point is taken while it waits, and a
// later result holds back only until it drains.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module projected_bbox_fit_scale_core #(
   parameter int COORD_BITS     = pbfs_pkg::COORD_BITS_DEF,
   parameter int COEF_FRAC_BITS = pbfs_pkg::COEF_FRAC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // point channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // grid_col, grid_row, height_val from bit 0 up, zero padded
   input  logic [((2*COORD_BITS+pbfs_pkg::HGT_W+7)/8)*8-1:0] req_tdata,
   input  logic                            req_tlast,   // last_point
   // result channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pbfs_pkg::SCALE_W-1:0]    rsp_tdata,   // fit_scale
   output logic                            rsp_tuser,   // degenerate
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [pbfs_pkg::CSR_ADDR_W-1:0] csr_addr,
   input  logic [pbfs_pkg::COEF_W-1:0]     csr_wdata
);

   pbfs_pkg::cmd_type cmd;
   pbfs_pkg::sts_type sts;

   // Registers always take a write
   assign csr_ready = 1'b1;

   pbfs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pbfs_dp #(
      .COORD_BITS     (COORD_BITS),
      .COEF_FRAC_BITS (COEF_FRAC_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .csr_valid  (csr_valid),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .cmd        (cmd),
      .sts        (sts)
   );

`ifndef ASSERT_OFF
   // Never overwrite a result that is still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> !sts.rsp_full)
      else $error("result committed over a pending word");

   // At most one datapath operation per cycle
   a_one_cmd: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.capture, cmd.mult, cmd.sum, cmd.box, cmd.ext,
                cmd.div_load, cmd.div_step, cmd.pick, cmd.finish}))
      else $error("overlapping datapath commands");

   // Divider never loads a zero extent
   a_no_zero_div: assert property (@(posedge clock) disable iff (reset)
      cmd.div_load |-> (cmd.axis ? !sts.ey_zero : !sts.ex_zero))
      else $error("divider loaded with zero extent");

   // Box update comes in the cycle after a sum
   a_box_order: assert property (@(posedge clock) disable iff (reset)
      cmd.box |-> $past(cmd.sum))
      else $error("box updated without a fresh projection");
`endif

endmodule
